// ===== hw/rtl/apc_pkg.sv =====
// ----------------------------------------------------------------------------
// apc_pkg
// Shared constants, codes and types of the adaptive penalty controller.
// ----------------------------------------------------------------------------
package apc_pkg;

  // sliding window geometry
  localparam int unsigned WINDOW_LEN = 100;
  localparam int unsigned CNT_W      = $clog2(WINDOW_LEN + 1);
  localparam int unsigned CNT_OUT_W  = 7;

  // signed width for the feasible fraction compare
  localparam int unsigned CMP_W = CNT_W + 19;

  // field widths
  localparam int unsigned PEN_W    = 33;
  localparam int unsigned TARGET_W = 16;
  localparam int unsigned INC_W    = 18;
  localparam int unsigned DEC_W    = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = PEN_W;

  // band half-width, 0.05 in Q0.16
  localparam int unsigned BAND_Q16 = 3277;

  // penalty bounds in Q.16: 0.1 and 100000
  localparam logic [PEN_W-1:0] PEN_MIN = 33'd6554;
  localparam logic [PEN_W-1:0] PEN_MAX = 33'd6553600000;

  // register reset values
  localparam logic [TARGET_W-1:0] TARGET_RST  = 16'd13107;
  localparam logic [INC_W-1:0]    INC_RST     = 18'd78643;
  localparam logic [DEC_W-1:0]    DEC_RST     = 17'd55705;
  localparam logic [PEN_W-1:0]    PEN_INIT_RST = 33'd65536;

  // request opcodes
  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_ADJUST = 1'b1
  } apc_op_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET      = 3'd0,
    REG_INC_FACTOR  = 3'd1,
    REG_DEC_FACTOR  = 3'd2,
    REG_INIT_CAP    = 3'd3,
    REG_INIT_DUR    = 3'd4
  } apc_reg_e;

  // per-cycle command to the window and penalty units
  typedef struct packed {
    logic record;
    logic adjust;
  } apc_cmd_t;

  // adjust settings shared by both penalty channels
  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [INC_W-1:0]    inc_factor;
    logic [DEC_W-1:0]    dec_factor;
  } apc_cfg_t;

endpackage

// ===== hw/rtl/apc_if.sv =====
// ----------------------------------------------------------------------------
// apc request and result channels
// Valid/ready channels carrying controller requests and results.
// ----------------------------------------------------------------------------
interface apc_req_if;
  logic valid;
  logic ready;
  logic opcode;
  logic load_ok;
  logic duration_ok;

  modport source (output valid, output opcode, output load_ok, output duration_ok,
                  input ready);
  modport sink   (input valid, input opcode, input load_ok, input duration_ok,
                  output ready);
endinterface

interface apc_rsp_if;
  logic        valid;
  logic        ready;
  logic [32:0] capacity_penalty_out;
  logic [32:0] duration_penalty_out;
  logic [6:0]  load_ok_count;
  logic [6:0]  duration_ok_count;

  modport source (output valid, output capacity_penalty_out, output duration_penalty_out,
                  output load_ok_count, output duration_ok_count, input ready);
  modport sink   (input valid, input capacity_penalty_out, input duration_penalty_out,
                  input load_ok_count, input duration_ok_count, output ready);
endinterface

// ===== hw/rtl/adaptive_penalty_controller_core.sv =====
// ----------------------------------------------------------------------------
// adaptive_penalty_controller_core
// Feasibility windows and adaptive capacity and duration penalties.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request in the cycle
// after it is accepted, through an output register; the request side stays
// ready while a result waits as long as the result is taken in the same cycle.
// The penalty update, a 33 x 18 bit scale made from two narrower partial
// products, plus clamp, is combinational in each channel. Each window is a
// 100-flag shift line with a running count, set to all feasible at reset with
// no clearing pass. Configuration writes take effect at once; writing an
// initial penalty loads that penalty, clamped to [0.1, 100000].
module adaptive_penalty_controller_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  apc_req_if.sink                          req_i,
  apc_rsp_if.source                        rsp_o,
  input  logic                             cfg_we_i,
  input  logic [apc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [apc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import apc_pkg::*;

  apc_cfg_t          cfg_q;
  apc_cmd_t          cmd;
  logic              fire;
  logic              load_cap, load_dur;
  logic [CNT_W-1:0]  load_cnt_d, dur_cnt_d;
  logic [PEN_W-1:0]  cap_pen_d, dur_pen_d;
  logic [CNT_W+CNT_OUT_W-1:0] load_cnt_ext, dur_cnt_ext;

  logic                 rsp_valid_q;
  logic [PEN_W-1:0]     cap_out_q, dur_out_q;
  logic [CNT_OUT_W-1:0] load_cnt_q, dur_cnt_q;

  // request handshake
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign cmd.record  = fire && (req_i.opcode == OP_RECORD);
  assign cmd.adjust  = fire && (req_i.opcode == OP_ADJUST);

  // configuration registers
  assign load_cap = cfg_we_i && (cfg_idx_i == REG_INIT_CAP);
  assign load_dur = cfg_we_i && (cfg_idx_i == REG_INIT_DUR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target     <= TARGET_RST;
      cfg_q.inc_factor <= INC_RST;
      cfg_q.dec_factor <= DEC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET:     cfg_q.target     <= cfg_wdata_i[TARGET_W-1:0];
        REG_INC_FACTOR: cfg_q.inc_factor <= cfg_wdata_i[INC_W-1:0];
        REG_DEC_FACTOR: cfg_q.dec_factor <= cfg_wdata_i[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  // feasibility windows
  apc_window u_load_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .flag_i    (req_i.load_ok),
    .count_d_o (load_cnt_d)
  );

  apc_window u_dur_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .flag_i    (req_i.duration_ok),
    .count_d_o (dur_cnt_d)
  );

  // penalty channels, each steered by its own window count
  apc_penalty u_cap_pen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .count_i    (load_cnt_d),
    .load_en_i  (load_cap),
    .load_val_i (cfg_wdata_i[PEN_W-1:0]),
    .pen_d_o    (cap_pen_d)
  );

  apc_penalty u_dur_pen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .count_i    (dur_cnt_d),
    .load_en_i  (load_dur),
    .load_val_i (cfg_wdata_i[PEN_W-1:0]),
    .pen_d_o    (dur_pen_d)
  );

  // reported counts keep the low bits only
  assign load_cnt_ext = (CNT_W+CNT_OUT_W)'(load_cnt_d);
  assign dur_cnt_ext  = (CNT_W+CNT_OUT_W)'(dur_cnt_d);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cap_out_q  <= cap_pen_d;
      dur_out_q  <= dur_pen_d;
      load_cnt_q <= load_cnt_ext[CNT_OUT_W-1:0];
      dur_cnt_q  <= dur_cnt_ext[CNT_OUT_W-1:0];
    end
  end

  assign rsp_o.valid                = rsp_valid_q;
  assign rsp_o.capacity_penalty_out = cap_out_q;
  assign rsp_o.duration_penalty_out = dur_out_q;
  assign rsp_o.load_ok_count        = load_cnt_q;
  assign rsp_o.duration_ok_count    = dur_cnt_q;

endmodule

// ===== hw/rtl/apc_window.sv =====
// ----------------------------------------------------------------------------
// apc_window
// Shift line of the most recent feasibility flags with a running count of ones.
// ----------------------------------------------------------------------------
module apc_window (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  apc_pkg::apc_cmd_t     cmd_i,
  input  logic                  flag_i,
  output logic [apc_pkg::CNT_W-1:0] count_d_o
);
  import apc_pkg::*;

  logic [WINDOW_LEN-1:0] win_q, win_d;
  logic [WINDOW_LEN-1:0] win_shift;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  oldest;

  // oldest flag leaves at the far end, new flag enters at bit zero
  assign oldest    = win_q[WINDOW_LEN-1];
  assign win_shift = {win_q[WINDOW_LEN-2:0], flag_i};

  always_comb begin
    win_d   = win_q;
    count_d = count_q;
    if (cmd_i.record) begin
      win_d   = win_shift;
      count_d = count_q - CNT_W'(oldest) + CNT_W'(flag_i);
    end
  end

  // window starts full of feasible flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '1;
      count_q <= CNT_W'(WINDOW_LEN);
    end else begin
      win_q   <= win_d;
      count_q <= count_d;
    end
  end

  assign count_d_o = count_d;

endmodule

// ===== hw/rtl/apc_penalty.sv =====
// ----------------------------------------------------------------------------
// apc_penalty
// One penalty channel: band compare, scale by a Q.16 factor and clamp.
// ----------------------------------------------------------------------------
module apc_penalty (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  apc_pkg::apc_cmd_t              cmd_i,
  input  apc_pkg::apc_cfg_t              cfg_i,
  input  logic [apc_pkg::CNT_W-1:0]      count_i,
  input  logic                           load_en_i,
  input  logic [apc_pkg::PEN_W-1:0]      load_val_i,
  output logic [apc_pkg::PEN_W-1:0]      pen_d_o
);
  import apc_pkg::*;

  localparam logic signed [CMP_W-1:0] BandS = CMP_W'(BAND_Q16);
  localparam logic signed [CMP_W-1:0] WinS  = CMP_W'(WINDOW_LEN);

  logic [PEN_W-1:0]        pen_q, pen_d;
  logic signed [CMP_W-1:0] lhs, tgt, lo_thr, hi_thr;
  logic                    below, above;
  logic [INC_W-1:0]        factor;
  logic [16:0]             pen_hi;
  logic [15:0]             pen_lo;
  logic [34:0]             prod_hi;
  logic [33:0]             prod_lo;
  logic [35:0]             scaled;
  logic [PEN_W-1:0]        load_clamped;

  // feasible fraction against target band, both sides scaled to count * 2^16
  assign lhs    = signed'(CMP_W'({count_i, 16'b0}));
  assign tgt    = signed'(CMP_W'(cfg_i.target));
  assign lo_thr = (tgt - BandS) * WinS;
  assign hi_thr = (tgt + BandS) * WinS;
  assign below  = lhs < lo_thr;
  assign above  = lhs > hi_thr;

  // penalty times factor over 2^16, split into two partial products
  assign factor  = below ? cfg_i.inc_factor : INC_W'(cfg_i.dec_factor);
  assign pen_hi  = pen_q[32:16];
  assign pen_lo  = pen_q[15:0];
  assign prod_hi = 35'(pen_hi) * 35'(factor);
  assign prod_lo = 34'(pen_lo) * 34'(factor);
  assign scaled  = 36'(prod_hi) + 36'(prod_lo[33:16]);

  // written initial value is held inside the bounds
  always_comb begin
    if (load_val_i < PEN_MIN) begin
      load_clamped = PEN_MIN;
    end else if (load_val_i > PEN_MAX) begin
      load_clamped = PEN_MAX;
    end else begin
      load_clamped = load_val_i;
    end
  end

  // next penalty
  always_comb begin
    pen_d = pen_q;
    if (load_en_i) begin
      pen_d = load_clamped;
    end else if (cmd_i.adjust) begin
      if (below) begin
        if (pen_q < PEN_MAX) begin
          pen_d = (scaled > 36'(PEN_MAX)) ? PEN_MAX : scaled[PEN_W-1:0];
        end
      end else if (above) begin
        if (pen_q > PEN_MIN) begin
          pen_d = (scaled < 36'(PEN_MIN)) ? PEN_MIN : scaled[PEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= PEN_INIT_RST;
    end else begin
      pen_q <= pen_d;
    end
  end

  assign pen_d_o = pen_d;

endmodule

// ===== tb/apc_checker.sv =====
// ----------------------------------------------------------------------------
// apc_checker
// Watches the request, result and register write ports of the adaptive
// penalty controller, keeps its own copy of the feasibility windows and
// penalties, and compares every result with the predicted one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  apc_req_if                           req_i,
  apc_rsp_if                           rsp_i,
  input  logic                         cfg_we_i,
  input  logic [apc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [apc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                           fail_cnt_o,
  output int                           pending_o
);
  import apc_pkg::*;

  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned OWED_DEPTH  = 8;

  typedef struct packed {
    logic [PEN_W-1:0]     cap_pen;
    logic [PEN_W-1:0]     dur_pen;
    logic [CNT_OUT_W-1:0] load_cnt;
    logic [CNT_OUT_W-1:0] dur_cnt;
  } pen_result_t;

  // predicted controller state
  logic                load_flags [WINDOW_LEN];
  logic                dur_flags  [WINDOW_LEN];
  int unsigned         slot_ptr;
  int unsigned         load_ones;
  int unsigned         dur_ones;
  logic [TARGET_W-1:0] target_q16;
  logic [INC_W-1:0]    inc_q16;
  logic [DEC_W-1:0]    dec_q16;
  logic [PEN_W-1:0]    cap_pen;
  logic [PEN_W-1:0]    dur_pen;

  // results still owed by the block, oldest first
  pen_result_t owed_mem [OWED_DEPTH];
  int unsigned owed_rd;
  int unsigned owed_wr;
  int unsigned owed_cnt;

  // loaded penalties are held inside the legal band
  function automatic logic [PEN_W-1:0] bound_penalty(input logic [PEN_W-1:0] pen);
    if (pen < PEN_MIN) return PEN_MIN;
    if (pen > PEN_MAX) return PEN_MAX;
    return pen;
  endfunction

  // one channel of an adjust: compare the window fraction with the band
  function automatic logic [PEN_W-1:0] scale_penalty(input logic [PEN_W-1:0] pen,
                                                     input int unsigned ones);
    longint      lhs;
    longint      lo_lim;
    longint      hi_lim;
    logic [63:0] prod;
    logic [PEN_W-1:0] nxt;
    lhs    = longint'(ones) * 65536;
    lo_lim = (longint'(target_q16) - longint'(BAND_Q16)) * longint'(WINDOW_LEN);
    hi_lim = (longint'(target_q16) + longint'(BAND_Q16)) * longint'(WINDOW_LEN);
    nxt    = pen;
    if (lhs < lo_lim) begin
      // too few feasible: scale up, saturate at the top only
      if (pen < PEN_MAX) begin
        prod = (64'(pen) * 64'(inc_q16)) >> 16;
        nxt  = (prod > 64'(PEN_MAX)) ? PEN_MAX : prod[PEN_W-1:0];
      end
    end else if (lhs > hi_lim) begin
      // too many feasible: scale down, saturate at the bottom only
      if (pen > PEN_MIN) begin
        prod = (64'(pen) * 64'(dec_q16)) >> 16;
        nxt  = (prod < 64'(PEN_MIN)) ? PEN_MIN : prod[PEN_W-1:0];
      end
    end
    return nxt;
  endfunction

  task automatic check_field(input string label, input logic [PEN_W-1:0] want,
                             input logic [PEN_W-1:0] got);
    if (want !== got) begin
      fail_cnt_o++;
      if (fail_cnt_o <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pen_result_t want;
    pen_result_t fresh;
    if (!rst_ni) begin
      // state after reset: windows all feasible, registers at defaults
      for (int i = 0; i < WINDOW_LEN; i++) begin
        load_flags[i] = 1'b1;
        dur_flags[i]  = 1'b1;
      end
      slot_ptr   = 0;
      load_ones  = WINDOW_LEN;
      dur_ones   = WINDOW_LEN;
      target_q16 = TARGET_RST;
      inc_q16    = INC_RST;
      dec_q16    = DEC_RST;
      cap_pen    = bound_penalty(PEN_INIT_RST);
      dur_pen    = bound_penalty(PEN_INIT_RST);
      owed_rd    = 0;
      owed_wr    = 0;
      owed_cnt   = 0;
      fail_cnt_o = 0;
    end else begin
      // result taken: compare with the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_cnt == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= MAX_REPORTS)
            $display("%0t: result with none expected, cap %0d dur %0d", $time,
                     rsp_i.capacity_penalty_out, rsp_i.duration_penalty_out);
        end else begin
          want     = owed_mem[owed_rd];
          owed_rd  = (owed_rd + 1) % OWED_DEPTH;
          owed_cnt = owed_cnt - 1;
          check_field("capacity penalty", want.cap_pen, rsp_i.capacity_penalty_out);
          check_field("duration penalty", want.dur_pen, rsp_i.duration_penalty_out);
          check_field("load ok count", 33'(want.load_cnt), 33'(rsp_i.load_ok_count));
          check_field("duration ok count", 33'(want.dur_cnt), 33'(rsp_i.duration_ok_count));
        end
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TARGET:     target_q16 = cfg_wdata_i[TARGET_W-1:0];
          REG_INC_FACTOR: inc_q16    = cfg_wdata_i[INC_W-1:0];
          REG_DEC_FACTOR: dec_q16    = cfg_wdata_i[DEC_W-1:0];
          REG_INIT_CAP:   cap_pen    = bound_penalty(cfg_wdata_i);
          REG_INIT_DUR:   dur_pen    = bound_penalty(cfg_wdata_i);
          default: ;
        endcase
      end

      // request taken: update the windows or the penalties
      if (req_i.valid && req_i.ready) begin
        if (req_i.opcode == OP_RECORD) begin
          load_ones = load_ones - load_flags[slot_ptr] + req_i.load_ok;
          dur_ones  = dur_ones - dur_flags[slot_ptr] + req_i.duration_ok;
          load_flags[slot_ptr] = req_i.load_ok;
          dur_flags[slot_ptr]  = req_i.duration_ok;
          slot_ptr = (slot_ptr + 1) % WINDOW_LEN;
        end else begin
          cap_pen = scale_penalty(cap_pen, load_ones);
          dur_pen = scale_penalty(dur_pen, dur_ones);
        end
        fresh.cap_pen  = cap_pen;
        fresh.dur_pen  = dur_pen;
        fresh.load_cnt = load_ones[CNT_OUT_W-1:0];
        fresh.dur_cnt  = dur_ones[CNT_OUT_W-1:0];
        if (owed_cnt == OWED_DEPTH) begin
          fail_cnt_o++;
          if (fail_cnt_o <= MAX_REPORTS)
            $display("%0t: too many results owed, expected at most %0d, got %0d",
                     $time, OWED_DEPTH, owed_cnt + 1);
        end else begin
          owed_mem[owed_wr] = fresh;
          owed_wr  = (owed_wr + 1) % OWED_DEPTH;
          owed_cnt = owed_cnt + 1;
        end
      end
    end
    pending_o = owed_cnt;
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives feasibility records and penalty adjusts into the adaptive penalty
// controller under random gaps and back-pressure, walks the registers
// through their extremes, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import apc_pkg::*;

  localparam int unsigned NUM_SETTINGS      = 8;
  localparam int unsigned ITEMS_PER_SETTING = 125;
  localparam int unsigned LIMIT_CYCLES      = 200000;
  localparam int unsigned IDLE_PCT          = 28;
  localparam int unsigned SQUEEZE_AT        = 250;
  localparam int unsigned SQUEEZE_LEN       = 80;
  localparam int unsigned CALM_FROM         = 520;
  localparam int unsigned CALM_TO           = 680;
  localparam int unsigned QUIET_SETTING     = 4;
  localparam logic [TARGET_W-1:0] TARGET_MAX = '1;
  localparam logic [INC_W-1:0]    INC_MAX    = '1;
  localparam logic [INC_W-1:0]    INC_ONE    = 18'd65536;
  localparam logic [DEC_W-1:0]    DEC_ONE    = 17'd65536;
  localparam logic [PEN_W-1:0]    PEN_ALL    = '1;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int fail_cnt;
  int pending_cnt;

  int unsigned cycle_cnt    = 0;
  int unsigned rsp_taken    = 0;
  int unsigned squeeze_left = 0;
  bit          squeeze_done = 1'b0;
  bit          gaps_on      = 1'b1;
  int unsigned n_record     = 0;
  int unsigned n_adjust     = 0;

  apc_req_if req_if ();
  apc_rsp_if rsp_if ();

  adaptive_penalty_controller_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  apc_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending_cnt)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // cycle limit and taken-result count
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rsp_if.valid && rsp_if.ready) rsp_taken <= rsp_taken + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("[adaptive_penalty_controller_core] ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, one calm stretch
  always @(negedge clk) begin
    if (!squeeze_done && rsp_taken >= SQUEEZE_AT) begin
      squeeze_left = SQUEEZE_LEN;
      squeeze_done = 1'b1;
    end
    if (squeeze_left != 0) begin
      squeeze_left--;
      rsp_if.ready <= 1'b0;
    end else if (rsp_taken >= CALM_FROM && rsp_taken < CALM_TO) begin
      rsp_if.ready <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic logic [PEN_W-1:0] rand33();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[PEN_W-1:0];
  endfunction

  // random upper bits around the field, so the unused bits toggle too
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] field,
                                                       input int unsigned w);
    logic [CFG_DATA_W-1:0] mask;
    mask = (33'd1 << w) - 33'd1;
    return (rand33() & ~mask) | (field & mask);
  endfunction

  // initial penalty: mostly edges of the band and beyond
  function automatic logic [PEN_W-1:0] pick_init_pen();
    case ($urandom_range(7))
      0: return '0;
      1: return PEN_MIN - 33'd1;
      2: return PEN_MIN;
      3: return PEN_MAX;
      4: return PEN_MAX + 33'd1;
      5: return PEN_ALL;
      6: return PEN_MIN + 33'($urandom_range(1 << 20));
      default: return 33'(64'(rand33()) % 64'(PEN_MAX));
    endcase
  endfunction

  // chance in percent of a feasible flag
  function automatic int unsigned pick_bias();
    case ($urandom_range(3))
      0: return 0;
      1: return 100;
      default: return $urandom_range(100);
    endcase
  endfunction

  // one request, with random gaps ahead of it
  task automatic send_req(input apc_op_e op, input logic lf, input logic df);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.load_ok     <= lf;
    req_if.duration_ok <= df;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
    if (op == OP_RECORD) n_record++;
    else n_adjust++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // let every owed result come back before touching registers
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // stimulus
  initial begin
    int unsigned load_pct;
    int unsigned dur_pct;
    int unsigned adj_pct;
    logic [TARGET_W-1:0] tgt;
    logic [INC_W-1:0]    inc;
    logic [DEC_W-1:0]    dec;

    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_RECORD;
    req_if.load_ok     = 1'b0;
    req_if.duration_ok = 1'b0;
    rsp_if.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_TARGET;
    cfg_wdata          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: full windows above band, flags ignored on adjust, all flag pairs
    send_req(OP_ADJUST, 1'b1, 1'b1);
    send_req(OP_ADJUST, 1'b0, 1'b0);
    send_req(OP_RECORD, 1'b0, 1'b0);
    send_req(OP_RECORD, 1'b0, 1'b1);
    send_req(OP_RECORD, 1'b1, 1'b0);
    send_req(OP_RECORD, 1'b1, 1'b1);
    send_req(OP_ADJUST, 1'b1, 1'b0);

    // out-of-range loads, strongest increase, both inside band
    settle();
    cfg_write(REG_INIT_CAP, '0);
    cfg_write(REG_INIT_DUR, PEN_ALL);
    cfg_write(REG_TARGET, 33'(TARGET_MAX));
    cfg_write(REG_INC_FACTOR, 33'(INC_MAX));
    repeat (3) send_req(OP_ADJUST, 1'b0, 1'b1);

    // near the bounds, zero decrease, both above band
    settle();
    cfg_write(REG_INIT_CAP, PEN_MAX - 33'd1);
    cfg_write(REG_INIT_DUR, PEN_MIN + 33'd1);
    cfg_write(REG_TARGET, '0);
    cfg_write(REG_DEC_FACTOR, '0);
    repeat (2) send_req(OP_ADJUST, 1'b1, 1'b1);

    // increase factor below one and at zero
    settle();
    cfg_write(REG_TARGET, 33'(TARGET_MAX));
    cfg_write(REG_INC_FACTOR, 33'd32768);
    send_req(OP_ADJUST, 1'b0, 1'b0);
    settle();
    cfg_write(REG_INC_FACTOR, '0);
    send_req(OP_ADJUST, 1'b1, 1'b1);
    settle();
    cfg_write(REG_INIT_CAP, PEN_MIN - 33'd1);
    cfg_write(REG_DEC_FACTOR, 33'(DEC_ONE));
    cfg_write(REG_TARGET, '0);
    send_req(OP_ADJUST, 1'b0, 1'b1);

    // random phases, each under its own register setting
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      settle();
      case (s)
        0: begin
          tgt = '0;
          inc = INC_MAX;
          dec = '0;
        end
        1: begin
          tgt = TARGET_MAX;
          inc = INC_ONE;
          dec = DEC_ONE;
        end
        2: begin
          tgt = 16'($urandom_range(65535));
          inc = 18'($urandom_range(65535));
          dec = 17'($urandom_range(65536));
        end
        default: begin
          tgt = 16'($urandom_range(65535));
          inc = 18'($urandom_range(262143, 65536));
          dec = 17'($urandom_range(65536));
        end
      endcase
      cfg_write(REG_TARGET, with_noise(33'(tgt), TARGET_W));
      cfg_write(REG_INC_FACTOR, with_noise(33'(inc), INC_W));
      cfg_write(REG_DEC_FACTOR, with_noise(33'(dec), DEC_W));
      cfg_write(REG_INIT_CAP, pick_init_pen());
      cfg_write(REG_INIT_DUR, pick_init_pen());
      // unused index, must change nothing
      cfg_write(3'($urandom_range(7, REG_INIT_DUR + 1)), rand33());

      load_pct = pick_bias();
      dur_pct  = pick_bias();
      adj_pct  = $urandom_range(40, 5);
      gaps_on  = (s != QUIET_SETTING);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        if ($urandom_range(99) < adj_pct)
          send_req(OP_ADJUST, 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          send_req(OP_RECORD, $urandom_range(99) < load_pct, $urandom_range(99) < dur_pct);
      end
    end

    // wait out the tail and report
    gaps_on = 1'b1;
    settle();
    $display("covered %0d records and %0d adjusts over %0d register settings,",
             n_record, n_adjust, NUM_SETTINGS);
    $display("with saturated and out-of-range penalties and a %0d-cycle result stall",
             SQUEEZE_LEN);
    if (fail_cnt == 0) begin
      $display("[adaptive_penalty_controller_core] OK");
    end else begin
      $display("[adaptive_penalty_controller_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/apc_pkg.sv
hw/rtl/apc_if.sv
hw/rtl/apc_window.sv
hw/rtl/apc_penalty.sv
hw/rtl/adaptive_penalty_controller_core.sv
tb/apc_checker.sv
tb/testbench.sv
